// File: rtl/hsfe_pkg.sv
// Shared types, codes and frame constants for the screen frame encoder.
package hsfe_pkg;

    localparam int VALUE_W        = 16;
    localparam int VALUE_BITS_DEF = 16;
    localparam int MAX_DIGITS     = 5;
    localparam int POS_W          = 5;
    localparam int DIGIT_CNT_W    = 3;
    localparam int DIGIT_IDX_W    = $clog2(MAX_DIGITS);

    typedef enum logic [1:0] {
        OP_NUMERIC = 2'd0,
        OP_BUTTON  = 2'd1,
        OP_SWITCH  = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [7:0]         page;
        logic [7:0]         control_id;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } frame_t;

    // Status of the binary to decimal converter.
    typedef struct packed {
        logic busy;
        logic done;
    } bcd_stat_t;

    localparam logic [7:0] HDR_SYNC   = 8'hEE;
    localparam logic [7:0] HDR_CMD    = 8'hB1;
    localparam logic [7:0] SUB_UPDATE = 8'h10;
    localparam logic [7:0] SUB_SWITCH = 8'h00;
    localparam logic [7:0] PAD_ZERO   = 8'h00;
    localparam logic [7:0] TAIL_A     = 8'hFF;
    localparam logic [7:0] TAIL_B     = 8'hFC;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam logic [POS_W-1:0] LEN_SWITCH   = 5'd9;
    localparam logic [POS_W-1:0] LEN_BUTTON   = 5'd12;
    localparam logic [POS_W-1:0] LEN_NUM_BASE = 5'd11;

endpackage

// File: rtl/hsfe_bcd.sv
// Iterative binary to decimal converter, one shift-and-adjust step per cycle.
module hsfe_bcd
    import hsfe_pkg::*;
#(
    parameter int BIN_BITS = VALUE_W
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [BIN_BITS-1:0]                 bin,
    output bcd_stat_t                           stat,
    output logic [MAX_DIGITS-1:0][3:0]          digits
);

    localparam int CNT_W = $clog2(BIN_BITS + 1);

    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         done_reg, done_next;
    logic [BIN_BITS-1:0]          bin_reg, bin_next;
    logic [MAX_DIGITS-1:0][3:0]   bcd_reg, bcd_next;
    logic [MAX_DIGITS-1:0][3:0]   adj;
    logic [4*MAX_DIGITS:0]        shifted;

    // Each digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    assign shifted = {adj, bin_reg[BIN_BITS-1]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            cnt_next = CNT_W'(BIN_BITS);
            bin_next = bin;
            bcd_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            bin_next  = {bin_reg[BIN_BITS-2:0], 1'b0};
            bcd_next  = shifted[4*MAX_DIGITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign digits    = bcd_reg;

endmodule

// File: rtl/hmi_screen_frame_encoder_core.sv
// Top level of the touch-screen command frame encoder.
//
// A request transaction is taken on cmd at a rising edge where start is high
// and busy is low. Opcode OP_NONE is dropped: no bytes follow and busy stays
// low. Every other request produces one whole frame on the frame port, one
// byte per clock cycle, each byte marked by frame_strobe for exactly one
// cycle; frame.last flags the final byte of the frame.
//
// A numeric update first runs a shift-and-adjust binary to decimal
// conversion, one bit per cycle in the converter, and its frame is 12 to
// 16 bytes long. Button updates (12 bytes) and screen switches (9 bytes)
// skip the conversion and go straight to emitting bytes. busy drops in
// the cycle that carries the last byte, so the next request can be taken
// right then.
//
// Reset clears the sequencer, the held request and the converter counter;
// no output strobe is given until a request arrives. The receiver cannot
// stall this block: each byte is valid for one cycle only.
module hmi_screen_frame_encoder_core
    import hsfe_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  cmd_t   cmd,
    output frame_t frame,
    output logic   frame_strobe
);

    // Only the low bits of the value that survive both masks are kept.
    localparam int HELD_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    op_t                      held_op_reg, held_op_next;
    logic [7:0]               held_page_reg, held_page_next;
    logic [7:0]               held_control_reg, held_control_next;
    logic [HELD_BITS-1:0]     held_value_reg, held_value_next;
    logic [DIGIT_CNT_W-1:0]   digit_total_reg, digit_total_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [POS_W-1:0]         len_reg, len_next;
    frame_t                   frame_reg, frame_next;
    logic                     strobe_reg, strobe_next;

    logic                     accept;
    logic                     conv_start;
    bcd_stat_t                conv_stat;
    logic [MAX_DIGITS-1:0][3:0] digits;
    logic [DIGIT_CNT_W-1:0]   digit_count;
    logic [POS_W-1:0]         remain;
    logic [POS_W-1:0]         digit_sel;
    logic [7:0]               byte_val;

    assign accept     = start && (state_reg == ST_IDLE);
    assign conv_start = accept && (cmd.op == OP_NUMERIC);

    hsfe_bcd #(
        .BIN_BITS (HELD_BITS)
    ) u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .bin    (cmd.value[HELD_BITS-1:0]),
        .stat   (conv_stat),
        .digits (digits)
    );

    // Number of significant digits; zero still prints a single digit.
    always_comb
    begin
        if (digits[4] != 4'd0)
            digit_count = 3'd5;
        else if (digits[3] != 4'd0)
            digit_count = 3'd4;
        else if (digits[2] != 4'd0)
            digit_count = 3'd3;
        else if (digits[1] != 4'd0)
            digit_count = 3'd2;
        else
            digit_count = 3'd1;
    end

    // Bytes left after this one, and the digit that belongs at this position.
    // The most significant printed digit sits in slot digit_total_reg-1 of the converter.
    assign remain    = len_reg - pos_reg - 5'd1;
    assign digit_sel = 5'(digit_total_reg) + 5'd6 - pos_reg;

    always_comb
    begin
        byte_val = PAD_ZERO;
        if (remain < 5'd4)
        begin
            byte_val = (remain == 5'd2) ? TAIL_B : TAIL_A;
        end
        else if (held_op_reg == OP_SWITCH)
        begin
            case (pos_reg)
                5'd0:    byte_val = HDR_SYNC;
                5'd1:    byte_val = HDR_CMD;
                5'd2:    byte_val = SUB_SWITCH;
                5'd4:    byte_val = held_page_reg;
                default: byte_val = PAD_ZERO;
            endcase
        end
        else
        begin
            case (pos_reg)
                5'd0:    byte_val = HDR_SYNC;
                5'd1:    byte_val = HDR_CMD;
                5'd2:    byte_val = SUB_UPDATE;
                5'd3:    byte_val = PAD_ZERO;
                5'd4:    byte_val = held_page_reg;
                5'd5:    byte_val = PAD_ZERO;
                5'd6:    byte_val = held_control_reg;
                default:
                begin
                    if (held_op_reg == OP_BUTTON)
                        byte_val = held_value_reg[7:0];
                    else
                        byte_val = ASCII_ZERO
                                 | {4'd0, digits[digit_sel[DIGIT_IDX_W-1:0]]};
                end
            endcase
        end
    end

    // Sequencer: capture the request, wait for the converter on numeric updates, stream bytes.
    always_comb
    begin
        state_next        = state_reg;
        held_op_next      = held_op_reg;
        held_page_next    = held_page_reg;
        held_control_next = held_control_reg;
        held_value_next   = held_value_reg;
        digit_total_next  = digit_total_reg;
        pos_next          = pos_reg;
        len_next          = len_reg;
        frame_next        = frame_reg;
        strobe_next       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.op != OP_NONE))
                begin
                    held_op_next      = cmd.op;
                    held_page_next    = cmd.page;
                    held_control_next = cmd.control_id;
                    held_value_next   = cmd.value[HELD_BITS-1:0];
                    pos_next          = '0;
                    case (cmd.op)
                        OP_NUMERIC:
                        begin
                            state_next = ST_CONV;
                        end
                        OP_BUTTON:
                        begin
                            len_next   = LEN_BUTTON;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            len_next   = LEN_SWITCH;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                if (conv_stat.done)
                begin
                    digit_total_next = digit_count;
                    len_next         = LEN_NUM_BASE + 5'(digit_count);
                    state_next       = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                frame_next.out_byte = byte_val;
                frame_next.last     = (remain == '0);
                strobe_next         = 1'b1;
                if (remain == '0)
                begin
                    pos_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            held_op_reg      <= OP_NUMERIC;
            held_page_reg    <= '0;
            held_control_reg <= '0;
            held_value_reg   <= '0;
            digit_total_reg  <= '0;
            pos_reg          <= '0;
            len_reg          <= '0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            held_op_reg      <= held_op_next;
            held_page_reg    <= held_page_next;
            held_control_reg <= held_control_next;
            held_value_reg   <= held_value_next;
            digit_total_reg  <= digit_total_next;
            pos_reg          <= pos_next;
            len_reg          <= len_next;
            strobe_reg       <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign frame        = frame_reg;
    assign frame_strobe = strobe_reg;

    // The last byte of a frame comes out as the block becomes free again.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        frame_strobe && frame.last |-> !busy)
        else $error("last frame byte seen while still busy");

    // A valid request always makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.op != OP_NONE) |=> busy)
        else $error("accepted request did not start a frame");

    // The converter only finishes while the sequencer waits for it.
    a_conv_owner: assert property (@(posedge clk) disable iff (!rst_n)
        conv_stat.done |-> (state_reg == ST_CONV) && !conv_stat.busy)
        else $error("converter finished outside the conversion wait");

    // The byte pointer never runs past the frame length.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg < len_reg))
        else $error("byte position beyond frame length");

endmodule
